>>> hw/rtl/spbc_pkg.sv
// Shared types and constants of the servo preset button controller.
// Used by spbc_csr, spbc_core and the top level; depends on nothing.
package spbc_pkg;

   localparam int PULSE_OUT_BITS = 12;
   localparam int PERIOD_BITS    = 10;
   localparam int COUNT_BITS     = 8;
   localparam int STEP_BITS      = 8;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 12;
   localparam int NUM_PRESETS    = 2;

   // Register indexes on the csr port
   localparam logic [CSR_ADDR_BITS-1:0] CSR_MEM_PERIOD  = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STEP_PERIOD = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LONG_PRESS  = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STEP_SIZE   = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PULSE_MIN   = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PULSE_MAX   = 3'd5;

   // Register values after reset
   localparam logic [PERIOD_BITS-1:0]    RST_MEM_PERIOD  = 10'd10;
   localparam logic [PERIOD_BITS-1:0]    RST_STEP_PERIOD = 10'd20;
   localparam logic [COUNT_BITS-1:0]     RST_LONG_PRESS  = 8'd50;
   localparam logic [STEP_BITS-1:0]      RST_STEP_SIZE   = 8'd10;
   localparam logic [PULSE_OUT_BITS-1:0] RST_PULSE_MIN   = 12'd1100;
   localparam logic [PULSE_OUT_BITS-1:0] RST_PULSE_MAX   = 12'd2100;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [PERIOD_BITS-1:0]    mem_period;
      logic [PERIOD_BITS-1:0]    step_period;
      logic [COUNT_BITS-1:0]     long_press_count;
      logic [STEP_BITS-1:0]      step_size;
      logic [PULSE_OUT_BITS-1:0] pulse_min;
      logic [PULSE_OUT_BITS-1:0] pulse_max;
   } cfg_type;

   typedef struct packed {
      logic program_mode;
      logic step_up;
      logic step_down;
      logic preset_a_button;
      logic preset_b_button;
   } req_type;

   typedef struct packed {
      logic [PULSE_OUT_BITS-1:0] pulse_width;
      logic                      led_up;
      logic                      led_down;
      logic                      led_saved;
      logic                      led_recalled;
   } rsp_type;

endpackage

>>> hw/rtl/servo_preset_button_controller.sv
// Top level of the servo preset button controller: stream ports, input and
// result registers. Depends on spbc_pkg, spbc_csr and spbc_core.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+-----------------------------------
//   req_    | in  | req_tvalid / req_tready   | req_tdata: 5 switch levels, 1 tick
//   rsp_    | out | rsp_tvalid / rsp_tready   | rsp_tdata: pulse width and LEDs
//   csr_    | in  | csr_we                    | csr_addr, csr_wdata: register write
//
// One transaction per cycle sustained while rsp_ is not stalled; each tick's result
// leaves through the input register, then the result register.
// The scheduler and task logic sits between the two registers and updates
// all state in the cycle the held tick moves into the result register.
// A stalled rsp_ side holds the result; the input register still takes one
// more tick, then req_tready drops until the result is taken.
// Synchronous reset clears core state, LED flags and both valid flags.
module servo_preset_button_controller
   import spbc_pkg::*;
#(
   parameter int PULSE_BITS = 12
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [0] program_mode, [1] step_up, [2] step_down,
   // [3] preset_a_button, [4] preset_b_button, [7:5] zero
   input  logic [7:0]               req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [11:0] pulse_width, [12] led_up, [13] led_down,
   // [14] led_saved, [15] led_recalled
   output logic [15:0]              rsp_tdata,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type cfg;
   req_type in_item_ff;
   logic    in_valid_ff, in_valid_in;
   rsp_type out_rsp_ff;
   rsp_type core_rsp;
   logic    out_valid_ff, out_valid_in;
   logic    advance;
   logic    req_take;

   spbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spbc_core #(
      .PULSE_BITS (PULSE_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (in_item_ff),
      .result  (core_rsp)
   );

   // Advance the held tick whenever the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers: load on a transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff.program_mode    <= req_tdata[0];
         in_item_ff.step_up         <= req_tdata[1];
         in_item_ff.step_down       <= req_tdata[2];
         in_item_ff.preset_a_button <= req_tdata[3];
         in_item_ff.preset_b_button <= req_tdata[4];
      end
      if (advance) begin
         out_rsp_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_rsp_ff.led_recalled, out_rsp_ff.led_saved,
                        out_rsp_ff.led_down, out_rsp_ff.led_up,
                        out_rsp_ff.pulse_width};

   // an accepted transaction always lands in the input register
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted transaction lost");

   // a tick that moves on always produces a result
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("result dropped");

   // a held tick stays held while the result side is blocked
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("held tick lost or altered under stall");

endmodule

>>> hw/rtl/spbc_csr.sv
// Configuration register bank of the servo preset button controller.
// Depends on spbc_pkg.
module spbc_csr
   import spbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MEM_PERIOD:  cfg_in.mem_period       = csr_wdata[PERIOD_BITS-1:0];
            CSR_STEP_PERIOD: cfg_in.step_period      = csr_wdata[PERIOD_BITS-1:0];
            CSR_LONG_PRESS:  cfg_in.long_press_count = csr_wdata[COUNT_BITS-1:0];
            CSR_STEP_SIZE:   cfg_in.step_size        = csr_wdata[STEP_BITS-1:0];
            CSR_PULSE_MIN:   cfg_in.pulse_min        = csr_wdata[PULSE_OUT_BITS-1:0];
            CSR_PULSE_MAX:   cfg_in.pulse_max        = csr_wdata[PULSE_OUT_BITS-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mem_period       <= RST_MEM_PERIOD;
         cfg_ff.step_period      <= RST_STEP_PERIOD;
         cfg_ff.long_press_count <= RST_LONG_PRESS;
         cfg_ff.step_size        <= RST_STEP_SIZE;
         cfg_ff.pulse_min        <= RST_PULSE_MIN;
         cfg_ff.pulse_max        <= RST_PULSE_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> hw/rtl/spbc_core.sv
// Task scheduler, press classifier, clamp and step logic with its state.
// Depends on spbc_pkg; state advances once per transaction (step_en).
module spbc_core
   import spbc_pkg::*;
#(
   parameter int PULSE_BITS = 12
)
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    step_en,
   input  req_type item,
   output rsp_type result
);

   localparam int POS_BITS = (PULSE_BITS > PULSE_OUT_BITS) ? PULSE_BITS : PULSE_OUT_BITS;
   localparam logic [POS_BITS-1:0] POS_MASK =
      POS_BITS'((64'd1 << PULSE_BITS) - 64'd1);

   logic [PERIOD_BITS-1:0]                      mem_cnt_ff, mem_cnt_in;
   logic [PERIOD_BITS-1:0]                      step_cnt_ff, step_cnt_in;
   logic [NUM_PRESETS-1:0][COUNT_BITS-1:0]      press_ff, press_in;
   logic [NUM_PRESETS-1:0][PULSE_BITS-1:0]      preset_ff, preset_in;
   logic [POS_BITS-1:0]                         position_ff, position_in;
   logic [PULSE_OUT_BITS-1:0]                   latch_ff, latch_in;
   logic                                        led_up_ff, led_up_in;
   logic                                        led_down_ff, led_down_in;
   logic                                        led_saved_ff, led_saved_in;
   logic                                        led_recalled_ff, led_recalled_in;
   logic                                        mem_run, step_run;

   assign mem_run  = (mem_cnt_ff == '0);
   assign step_run = (step_cnt_ff == '0);

   always_comb begin
      logic                  pressed;
      logic [COUNT_BITS-1:0] cnt;
      logic [POS_BITS:0]     sum;

      mem_cnt_in      = mem_run ? cfg.mem_period : mem_cnt_ff - 1'b1;
      step_cnt_in     = step_run ? cfg.step_period : step_cnt_ff - 1'b1;
      press_in        = press_ff;
      preset_in       = preset_ff;
      position_in     = position_ff;
      latch_in        = latch_ff;
      led_up_in       = led_up_ff;
      led_down_in     = led_down_ff;
      led_saved_in    = led_saved_ff;
      led_recalled_in = led_recalled_ff;
      pressed         = 1'b0;
      cnt             = '0;
      sum             = '0;

      // Memory task: button A, then button B, then clamp and latch
      if (mem_run) begin
         for (int k = 0; k < NUM_PRESETS; k++) begin
            pressed = (k == 0) ? item.preset_a_button : item.preset_b_button;
            cnt     = press_ff[k];
            if (pressed) begin
               if (cnt < cfg.long_press_count) begin
                  press_in[k] = cnt + 1'b1;
               end else if (cnt == cfg.long_press_count) begin
                  if (cnt != COUNT_MAX) begin
                     press_in[k] = cnt + 1'b1;
                  end
                  if (item.program_mode) begin
                     preset_in[k] = position_in[PULSE_BITS-1:0];
                     led_saved_in = 1'b1;
                  end
               end
            end else begin
               // short press recalls the stored preset
               if (cnt < cfg.long_press_count && cnt != '0) begin
                  position_in     = POS_BITS'(preset_in[k]);
                  led_recalled_in = 1'b1;
               end
               if (cnt != '0) begin
                  led_saved_in = 1'b0;
               end
               press_in[k] = '0;
            end
         end
         // pulse_max first, then pulse_min wins on inverted bounds
         if (position_in > POS_BITS'(cfg.pulse_max)) begin
            position_in = POS_BITS'(cfg.pulse_max);
         end
         if (position_in < POS_BITS'(cfg.pulse_min)) begin
            position_in = POS_BITS'(cfg.pulse_min);
         end
         latch_in = PULSE_OUT_BITS'(position_in & POS_MASK);
      end

      // Step task: up then down, each saturating on its own
      if (step_run && item.program_mode) begin
         if (item.step_up) begin
            sum = {1'b0, position_in} + (POS_BITS+1)'(cfg.step_size);
            if (sum > {1'b0, POS_MASK}) begin
               position_in = POS_MASK;
            end else begin
               position_in = sum[POS_BITS-1:0];
            end
            led_up_in       = 1'b1;
            led_recalled_in = 1'b0;
         end else begin
            led_up_in = 1'b0;
         end
         if (item.step_down) begin
            if (position_in > POS_BITS'(cfg.step_size)) begin
               position_in = position_in - POS_BITS'(cfg.step_size);
            end else begin
               position_in = '0;
            end
            led_down_in     = 1'b1;
            led_recalled_in = 1'b0;
         end else begin
            led_down_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_cnt_ff      <= '0;
         step_cnt_ff     <= '0;
         press_ff        <= '0;
         preset_ff       <= '0;
         position_ff     <= '0;
         latch_ff        <= '0;
         led_up_ff       <= 1'b0;
         led_down_ff     <= 1'b0;
         led_saved_ff    <= 1'b0;
         led_recalled_ff <= 1'b0;
      end else if (step_en) begin
         mem_cnt_ff      <= mem_cnt_in;
         step_cnt_ff     <= step_cnt_in;
         press_ff        <= press_in;
         preset_ff       <= preset_in;
         position_ff     <= position_in;
         latch_ff        <= latch_in;
         led_up_ff       <= led_up_in;
         led_down_ff     <= led_down_in;
         led_saved_ff    <= led_saved_in;
         led_recalled_ff <= led_recalled_in;
      end
   end

   assign result.pulse_width  = latch_in;
   assign result.led_up       = led_up_in;
   assign result.led_down     = led_down_in;
   assign result.led_saved    = led_saved_in;
   assign result.led_recalled = led_recalled_in;

   // any step run in program mode with a step switch set clears the recall indicator
   a_step_clears_recall: assert property (@(posedge clock) disable iff (reset)
      (step_en && step_run && item.program_mode && (item.step_up || item.step_down))
      |=> !led_recalled_ff)
      else $error("recall indicator survived a step");

   // the pulse latch only moves on a memory task run
   a_latch_only_on_mem_run: assert property (@(posedge clock) disable iff (reset)
      (step_en && !mem_run) |=> $stable(latch_ff))
      else $error("pulse latch changed outside the memory task");

   // the memory countdown reloads exactly when it ran
   a_mem_reload: assert property (@(posedge clock) disable iff (reset)
      (step_en && mem_run) |=> (mem_cnt_ff == $past(cfg.mem_period)))
      else $error("memory task countdown not reloaded");

endmodule

>>> test/spbc_pulse_checker.sv
// Checker of the servo preset button controller: watches the tick, result and
// register channels, predicts each tick's outputs and compares them.
// Depends on spbc_pkg for register indexes, reset values and field types.
module spbc_pulse_checker
   import spbc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   input  logic                     req_tready,
   input  logic [7:0]               req_tdata,
   input  logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   input  logic [15:0]              rsp_tdata,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output int                       mismatches,
   output int                       pending
);

   localparam int POS_LIMIT = (1 << PULSE_OUT_BITS) - 1;

   cfg_type                   cfg;
   logic [PERIOD_BITS-1:0]    mem_countdown;
   logic [PERIOD_BITS-1:0]    step_countdown;
   logic [COUNT_BITS-1:0]     hold_runs [NUM_PRESETS];
   logic [PULSE_OUT_BITS-1:0] position;
   logic [PULSE_OUT_BITS-1:0] saved_pos [NUM_PRESETS];
   logic [PULSE_OUT_BITS-1:0] latched_pulse;
   logic                      lit_up, lit_down, lit_saved, lit_recalled;

   rsp_type expected_outputs[$];
   rsp_type want, got;

   // One memory-task pass over a preset button.
   function automatic void track_button(int k, logic pressed, logic prog);
      logic [COUNT_BITS-1:0] c;
      c = hold_runs[k];
      if (pressed) begin
         if (c < cfg.long_press_count) begin
            c = c + 1'b1;
         end else if (c == cfg.long_press_count) begin
            if (c != COUNT_MAX) c = c + 1'b1;
            if (prog) begin
               saved_pos[k] = position;
               lit_saved    = 1'b1;
            end
         end
         hold_runs[k] = c;
      end else begin
         if (c < cfg.long_press_count && c != '0) begin
            position     = saved_pos[k];
            lit_recalled = 1'b1;
         end
         if (c != '0) lit_saved = 1'b0;
         hold_runs[k] = '0;
      end
   endfunction

   // Advance the scheduler by one tick and return the outputs it shows.
   function automatic rsp_type predict_tick(logic [4:0] sw);
      logic                    prog, up, down;
      logic [PULSE_OUT_BITS:0] sum;
      rsp_type                 r;
      prog = sw[0];
      up   = sw[1];
      down = sw[2];
      if (mem_countdown == '0) begin
         mem_countdown = cfg.mem_period;
         track_button(0, sw[3], prog);
         track_button(1, sw[4], prog);
         if (position > cfg.pulse_max) position = cfg.pulse_max;
         if (position < cfg.pulse_min) position = cfg.pulse_min;
         latched_pulse = position;
      end else begin
         mem_countdown = mem_countdown - 1'b1;
      end
      if (step_countdown == '0) begin
         step_countdown = cfg.step_period;
         if (prog) begin
            if (up) begin
               sum          = {1'b0, position} + cfg.step_size;
               position     = (sum > POS_LIMIT) ? POS_LIMIT[PULSE_OUT_BITS-1:0]
                                                : sum[PULSE_OUT_BITS-1:0];
               lit_up       = 1'b1;
               lit_recalled = 1'b0;
            end else begin
               lit_up = 1'b0;
            end
            if (down) begin
               position     = (position > cfg.step_size) ? position - cfg.step_size : '0;
               lit_down     = 1'b1;
               lit_recalled = 1'b0;
            end else begin
               lit_down = 1'b0;
            end
         end
      end else begin
         step_countdown = step_countdown - 1'b1;
      end
      r.pulse_width  = latched_pulse;
      r.led_up       = lit_up;
      r.led_down     = lit_down;
      r.led_saved    = lit_saved;
      r.led_recalled = lit_recalled;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         cfg.mem_period       = RST_MEM_PERIOD;
         cfg.step_period      = RST_STEP_PERIOD;
         cfg.long_press_count = RST_LONG_PRESS;
         cfg.step_size        = RST_STEP_SIZE;
         cfg.pulse_min        = RST_PULSE_MIN;
         cfg.pulse_max        = RST_PULSE_MAX;
         mem_countdown        = '0;
         step_countdown       = '0;
         position             = '0;
         latched_pulse        = '0;
         foreach (hold_runs[k]) hold_runs[k] = '0;
         foreach (saved_pos[k]) saved_pos[k] = '0;
         lit_up       = 1'b0;
         lit_down     = 1'b0;
         lit_saved    = 1'b0;
         lit_recalled = 1'b0;
         mismatches   = 0;
         expected_outputs.delete();
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_MEM_PERIOD:  cfg.mem_period       = csr_wdata[PERIOD_BITS-1:0];
               CSR_STEP_PERIOD: cfg.step_period      = csr_wdata[PERIOD_BITS-1:0];
               CSR_LONG_PRESS:  cfg.long_press_count = csr_wdata[COUNT_BITS-1:0];
               CSR_STEP_SIZE:   cfg.step_size        = csr_wdata[STEP_BITS-1:0];
               CSR_PULSE_MIN:   cfg.pulse_min        = csr_wdata[PULSE_OUT_BITS-1:0];
               CSR_PULSE_MAX:   cfg.pulse_max        = csr_wdata[PULSE_OUT_BITS-1:0];
               default: ;
            endcase
         end
         // pop before push: a result never belongs to the tick taken this edge
         if (rsp_tvalid && rsp_tready) begin
            got.pulse_width  = rsp_tdata[11:0];
            got.led_up       = rsp_tdata[12];
            got.led_down     = rsp_tdata[13];
            got.led_saved    = rsp_tdata[14];
            got.led_recalled = rsp_tdata[15];
            if (expected_outputs.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected result: pulse %0d up %b down %b saved %b recalled %b",
                           got.pulse_width, got.led_up, got.led_down, got.led_saved,
                           got.led_recalled);
               mismatches = mismatches + 1;
            end else begin
               want = expected_outputs.pop_front();
               if (got.pulse_width  !== want.pulse_width  ||
                   got.led_up       !== want.led_up       ||
                   got.led_down     !== want.led_down     ||
                   got.led_saved    !== want.led_saved    ||
                   got.led_recalled !== want.led_recalled) begin
                  if (mismatches < 10) begin
                     $write("mismatch: expected pulse %0d up %b down %b saved %b recalled %b, ",
                            want.pulse_width, want.led_up, want.led_down, want.led_saved,
                            want.led_recalled);
                     $display("got pulse %0d up %b down %b saved %b recalled %b",
                              got.pulse_width, got.led_up, got.led_down, got.led_saved,
                              got.led_recalled);
                  end
                  mismatches = mismatches + 1;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_outputs.push_back(predict_tick(req_tdata[4:0]));
      end
      pending <= expected_outputs.size();
   end

endmodule

>>> test/tb_servo_preset_button_controller.sv
// Testbench top of the servo preset button controller: clock, reset, tick and
// register stimulus, result back-pressure and the verdict.
// Depends on spbc_pkg, the block's RTL and spbc_pulse_checker.
module tb_servo_preset_button_controller
   import spbc_pkg::*;
;

   // Switch bits of one tick, as packed into req_tdata
   localparam logic [4:0] SW_NONE = 5'b00000;
   localparam logic [4:0] SW_PROG = 5'b00001;
   localparam logic [4:0] SW_UP   = 5'b00010;
   localparam logic [4:0] SW_DOWN = 5'b00100;
   localparam logic [4:0] SW_A    = 5'b01000;
   localparam logic [4:0] SW_B    = 5'b10000;
   localparam logic [4:0] SW_ALL  = 5'b11111;

   // Unused register indexes; writes there must be dropped
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_6 = 3'd6;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_7 = 3'd7;

   localparam int IDLE_PERCENT   = 36;
   localparam int RX_HOLD_CYCLES = 80;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata  = 8'h00;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [15:0]              rsp_tdata;
   logic                     csr_we     = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata  = '0;

   int      mismatches;
   int      pending;
   bit      calm          = 1'b0;   // no idling on either side while set
   int      hold_requests = 0;      // long receiver holds asked for
   int      holds_done    = 0;
   cfg_type active_setting;

   servo_preset_button_controller dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   spbc_pulse_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: take results with random gaps; on request hold off for a long
   // stretch so the block fills up and drops req_tready.
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done < hold_requests) begin
            rsp_tready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(posedge clock);
            holds_done = holds_done + 1;
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Hard stop in case the block wedges.
   initial begin
      #2000000;
      $display("servo_preset_button_controller test failed");
      $finish;
   end

   function automatic cfg_type setting(int mem_p, int step_p, int lpc, int ss, int lo, int hi);
      cfg_type s;
      s.mem_period       = mem_p[PERIOD_BITS-1:0];
      s.step_period      = step_p[PERIOD_BITS-1:0];
      s.long_press_count = lpc[COUNT_BITS-1:0];
      s.step_size        = ss[STEP_BITS-1:0];
      s.pulse_min        = lo[PULSE_OUT_BITS-1:0];
      s.pulse_max        = hi[PULSE_OUT_BITS-1:0];
      return s;
   endfunction

   // Offer one tick; hold it until the block takes the transaction.
   task automatic send_tick(input logic [4:0] sw);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, sw};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop offering and wait until every expected result has been taken.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all six registers while idle, with random bits above each field's
   // width, then poke both spare indexes.
   task automatic load_setting(input cfg_type s);
      logic [CSR_DATA_BITS-1:0] junk;
      drain();
      active_setting = s;
      junk = CSR_DATA_BITS'($urandom);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_MEM_PERIOD;
      csr_wdata <= {junk[CSR_DATA_BITS-1:PERIOD_BITS], s.mem_period};
      @(posedge clock);
      junk = CSR_DATA_BITS'($urandom);
      csr_addr  <= CSR_STEP_PERIOD;
      csr_wdata <= {junk[CSR_DATA_BITS-1:PERIOD_BITS], s.step_period};
      @(posedge clock);
      junk = CSR_DATA_BITS'($urandom);
      csr_addr  <= CSR_LONG_PRESS;
      csr_wdata <= {junk[CSR_DATA_BITS-1:COUNT_BITS], s.long_press_count};
      @(posedge clock);
      junk = CSR_DATA_BITS'($urandom);
      csr_addr  <= CSR_STEP_SIZE;
      csr_wdata <= {junk[CSR_DATA_BITS-1:STEP_BITS], s.step_size};
      @(posedge clock);
      csr_addr  <= CSR_PULSE_MIN;
      csr_wdata <= s.pulse_min;
      @(posedge clock);
      csr_addr  <= CSR_PULSE_MAX;
      csr_wdata <= s.pulse_max;
      @(posedge clock);
      csr_addr  <= CSR_SPARE_6;
      csr_wdata <= CSR_DATA_BITS'($urandom);
      @(posedge clock);
      csr_addr  <= CSR_SPARE_7;
      csr_wdata <= CSR_DATA_BITS'($urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed button presses (short, at the threshold, or long)
   // with random step switches, then a release gap; the rest is noise.
   task automatic run_phase(input int target);
      int         sent;
      int         span;
      int         lpc;
      int         runs;
      int         ticks;
      logic [1:0] btn;
      logic       prog;
      logic [4:0] sw;
      sent = 0;
      while (sent < target) begin
         span = int'(active_setting.mem_period) + 1;
         lpc  = int'(active_setting.long_press_count);
         if ($urandom_range(0, 99) < 80) begin
            btn  = 2'($urandom_range(1, 3));
            prog = ($urandom_range(0, 99) < 70);
            case ($urandom_range(0, 2))
               0:       runs = $urandom_range(1, (lpc > 1) ? lpc - 1 : 1);
               1:       runs = lpc + $urandom_range(0, 2);
               default: runs = $urandom_range(1, 2 * lpc + 4);
            endcase
            ticks = runs * span;
            if (ticks > 300) ticks = $urandom_range(1, 300);
            // keep the phase near its item budget
            if (ticks > target - sent) ticks = target - sent;
            repeat (ticks) begin
               if ($urandom_range(0, 99) < 5) prog = !prog;
               sw = {btn, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), prog};
               send_tick(sw);
               sent++;
            end
            // release both buttons for a while
            ticks = $urandom_range(1, 2 * span);
            if (ticks > 40) ticks = $urandom_range(1, 40);
            if (sent + ticks > target) ticks = (sent < target) ? target - sent : 1;
            repeat (ticks) begin
               sw = {2'b00, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), prog};
               send_tick(sw);
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 8)) begin
               send_tick(5'($urandom_range(0, 31)));
               sent++;
            end
         end
      end
   endtask

   initial begin
      active_setting = setting(10, 20, 50, 10, 1100, 2100);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every task runs on every tick, tiny long-press threshold.
      // Clamp pushes the position up, then step up saturates at the top.
      load_setting(setting(0, 0, 2, 255, 4000, 4095));
      send_tick(SW_NONE);
      send_tick(SW_PROG | SW_UP);
      send_tick(SW_PROG | SW_UP | SW_DOWN);   // both switches: up then down
      send_tick(SW_ALL);
      send_tick(SW_PROG | SW_A | SW_B);       // press reaches the threshold on both: no save yet
      send_tick(SW_PROG);                     // release after long: no recall
      send_tick(SW_A);
      send_tick(SW_NONE);                     // short press: recall
      // Step down saturates at zero.
      load_setting(setting(0, 0, 2, 255, 0, 100));
      send_tick(SW_PROG | SW_DOWN);
      send_tick(SW_PROG | SW_DOWN);
      send_tick(SW_B);
      send_tick(SW_NONE);
      // Zero threshold and inverted bounds.
      load_setting(setting(0, 0, 0, 1, 3000, 1000));
      send_tick(SW_PROG | SW_A);
      send_tick(SW_PROG | SW_A);
      send_tick(SW_NONE);
      send_tick(SW_PROG | SW_UP);
      // Threshold at the count's ceiling.
      load_setting(setting(0, 0, 255, 1, 0, 4095));
      repeat (4) send_tick(SW_PROG | SW_B);
      send_tick(SW_NONE);

      // Random phases across settings, extremes first.
      load_setting(setting(0, 0, 1, 1, 0, 4095));
      hold_requests = hold_requests + 1;      // long receiver hold-off
      run_phase(50);
      load_setting(setting(1, 3, 4, 255, 100, 4000));
      run_phase(25);
      drain();                                // sender pause until all results in
      run_phase(25);
      load_setting(setting(1023, 1023, 254, 128, 2000, 2000));
      run_phase(50);
      load_setting(setting(0, 1, 255, 37, 0, 4095));   // counts saturate
      run_phase(200);
      load_setting(setting(2, 0, 0, 200, 3000, 500));
      run_phase(50);
      calm = 1'b1;                            // long stretch without idling
      load_setting(setting(10, 20, 50, 10, 1100, 2100));
      run_phase(60);
      calm = 1'b0;
      repeat (4) begin
         load_setting(setting(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 6),
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                           : $urandom_range(0, 6),
                              ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 12),
                              $urandom_range(0, 255),
                              $urandom_range(0, 4095),
                              $urandom_range(0, 4095)));
         run_phase(45);
      end

      // Let the pipeline empty, then give the verdict.
      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("servo_preset_button_controller test passed");
      end else begin
         $display("servo_preset_button_controller test failed");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/spbc_pkg.sv
hw/rtl/spbc_csr.sv
hw/rtl/spbc_core.sv
hw/rtl/servo_preset_button_controller.sv
test/spbc_pulse_checker.sv
test/tb_servo_preset_button_controller.sv
